// File: rtl/ledbd_pkg.sv
`default_nettype none

package ledbd_pkg;

   // Function codes of an input word.
   localparam logic [2:0] FUNC_READ  = 3'd0;
   localparam logic [2:0] FUNC_WRITE = 3'd1;
   localparam logic [2:0] FUNC_COMP  = 3'd2;
   localparam logic [2:0] FUNC_INC   = 3'd3;
   localparam logic [2:0] FUNC_DEC   = 3'd4;
   localparam logic [2:0] FUNC_BLINK = 3'd5;
   localparam logic [2:0] FUNC_PWM   = 3'd6;

   // Register select codes.
   localparam logic [2:0] REG_LED   = 3'd0;
   localparam logic [2:0] REG_MASK  = 3'd1;
   localparam logic [2:0] REG_PHASE = 3'd2;
   localparam logic [2:0] REG_BRITE = 3'd3;
   localparam logic [2:0] REG_DIV   = 3'd4;

   localparam logic [15:0] ERR_DATA     = 16'hFFFF;
   localparam logic [7:0]  ALL_OFF      = 8'hFF;
   localparam logic [7:0]  BRIGHT_MAX   = 8'd255;
   localparam logic [7:0]  DIV_RESET    = 8'd4;
   localparam logic [7:0]  DIV_MAX      = 8'd255;
   localparam logic [7:0]  DIV_MIN      = 8'd1;
   localparam logic [7:0]  DEF_BRIGHT   = 8'd255;

   // The remainder unit retires one numerator bit per step.
   localparam int          NUM_W        = 9;
   localparam logic [3:0]  DIV_LAST     = 4'(NUM_W - 1);

   typedef struct packed {
      logic load;        // run a register access or pwm tick, load the result
      logic div_start;   // blink pulse accepted, set up the remainder unit
      logic div_step;    // one remainder step
      logic div_finish;  // commit the blink counter and load the result
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_blink;
      logic div_last;
   } ctrl_stat_type;

endpackage

`default_nettype wire

// File: rtl/ledbd_if.sv
`default_nettype none

interface ledbd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [2:0] reg_select;
   logic [7:0] value;

   modport source (output valid, func, reg_select, value, input ready);
   modport sink (input valid, func, reg_select, value, output ready);
endinterface

interface ledbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        error;
   logic [7:0]  led_drive;

   modport source (output valid, read_data, error, led_drive, input ready);
   modport sink (input valid, read_data, error, led_drive, output ready);
endinterface

interface ledbd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/ledbd_ctrl.sv
`default_nettype none

module ledbd_ctrl
   import ledbd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire ctrl_stat_type stat,
   output ctrl_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load       = accept && !stat.req_is_blink;
      cmd.div_start  = accept && stat.req_is_blink;
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.div_finish = (state_ff == ST_FIN) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.div_start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (cmd.div_finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load || cmd.div_finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ledbd_dp.sv
`default_nettype none

module ledbd_dp
   import ledbd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctrl_cmd_type cmd,
   output ctrl_stat_type     stat,
   input  wire logic [2:0]   req_func,
   input  wire logic [2:0]   req_reg_select,
   input  wire logic [7:0]   req_value,
   input  wire logic         csr_write,
   input  wire logic [7:0]   csr_data,
   output logic [15:0]       rsp_read_data,
   output logic              rsp_error,
   output logic [7:0]        rsp_led_drive
);

   logic [7:0] default_ff;
   logic [7:0] led_ff, led_in;
   logic [7:0] mask_ff, mask_in;
   logic [7:0] phase_sel_ff, phase_sel_in;
   logic [7:0] bright_ff, bright_in;
   logic [7:0] divider_ff, divider_in;
   logic [7:0] count_ff;
   logic       phase_ff;
   logic [7:0] pwm_ff, pwm_in;
   logic [7:0] drive_ff, drive_in;

   logic [NUM_W-1:0] num_ff;
   logic [7:0]       rem_ff;
   logic [3:0]       step_ff;
   logic [NUM_W-1:0] trial;

   logic [15:0] data_ff, data_in;
   logic        err_ff, err_in;
   logic [7:0]  led_out_ff;

   logic [7:0] plain_cur;
   logic [7:0] plain_new;
   logic [8:0] bright_sum;
   logic [7:0] shown;
   logic [7:0] phase_word;

   assign stat.req_is_blink = (req_func == FUNC_BLINK);
   assign stat.div_last     = (step_ff == DIV_LAST);

   assign phase_word = phase_ff ? 8'hFF : 8'h00;
   assign shown      = led_ff & (~mask_ff | (mask_ff & (phase_sel_ff ^ phase_word)));
   assign bright_sum = {1'b0, bright_ff} + {1'b0, req_value};

   always_comb begin
      case (req_reg_select)
         REG_LED:  plain_cur = led_ff;
         REG_MASK: plain_cur = mask_ff;
         default:  plain_cur = phase_sel_ff;
      endcase
      plain_new = (req_func == FUNC_WRITE) ? req_value :
                  (req_func == FUNC_COMP)  ? ~plain_cur : plain_cur;
   end

   // One register access or pwm tick. Unsupported operations change nothing.
   always_comb begin
      led_in       = led_ff;
      mask_in      = mask_ff;
      phase_sel_in = phase_sel_ff;
      bright_in    = bright_ff;
      divider_in   = divider_ff;
      pwm_in       = pwm_ff;
      drive_in     = drive_ff;
      data_in      = 16'd0;
      err_in       = 1'b0;
      if (req_func == FUNC_PWM) begin
         pwm_in = pwm_ff + 8'd1;
         if (pwm_in == 8'd0) drive_in = ~shown;
         // The turn-off wins over the wrap, so brightness zero stays dark.
         if (pwm_in == bright_ff && bright_ff != BRIGHT_MAX) drive_in = ALL_OFF;
      end else begin
         unique case (req_reg_select) inside
            REG_LED, REG_MASK, REG_PHASE: begin
               if (req_func == FUNC_READ || req_func == FUNC_WRITE ||
                   req_func == FUNC_COMP) begin
                  data_in = {8'd0, plain_new};
                  case (req_reg_select)
                     REG_LED:  led_in = plain_new;
                     REG_MASK: mask_in = plain_new;
                     default:  phase_sel_in = plain_new;
                  endcase
               end else begin
                  err_in = 1'b1;
               end
            end
            REG_BRITE: begin
               case (req_func)
                  FUNC_READ:  bright_in = bright_ff;
                  FUNC_WRITE: bright_in = req_value;
                  FUNC_INC:   bright_in = bright_sum[8] ? BRIGHT_MAX : bright_sum[7:0];
                  FUNC_DEC:   bright_in = (req_value > bright_ff) ? 8'd0
                                          : bright_ff - req_value;
                  default:    err_in = 1'b1;
               endcase
               if (!err_in) data_in = {8'd0, bright_in};
            end
            REG_DIV: begin
               case (req_func)
                  FUNC_READ:  divider_in = divider_ff;
                  FUNC_WRITE: if (req_value != 8'd0) divider_in = req_value;
                  FUNC_INC:   if (divider_ff < DIV_MAX) divider_in = divider_ff + 8'd1;
                  FUNC_DEC:   if (divider_ff > DIV_MIN) divider_in = divider_ff - 8'd1;
                  default:    err_in = 1'b1;
               endcase
               if (!err_in) data_in = {8'd0, divider_in};
            end
            default: err_in = 1'b1;
         endcase
         if (err_in) data_in = ERR_DATA;
      end
   end

   // Restoring remainder step; the partial remainder always stays below the divider.
   assign trial = {rem_ff, num_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff  <= {1'b0, count_ff} + 9'd1;
         rem_ff  <= 8'd0;
         step_ff <= 4'd0;
      end else if (cmd.div_step) begin
         num_ff  <= {num_ff[NUM_W-2:0], 1'b0};
         step_ff <= step_ff + 4'd1;
         if (trial >= {1'b0, divider_ff}) rem_ff <= 8'(trial - {1'b0, divider_ff});
         else rem_ff <= trial[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= DEF_BRIGHT;
      end else if (csr_write) begin
         default_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff       <= 8'd0;
         mask_ff      <= 8'd0;
         phase_sel_ff <= 8'd0;
         bright_ff    <= default_ff;
         divider_ff   <= DIV_RESET;
         count_ff     <= 8'd0;
         phase_ff     <= 1'b0;
         pwm_ff       <= 8'd0;
         drive_ff     <= ALL_OFF;
      end else if (cmd.load) begin
         led_ff       <= led_in;
         mask_ff      <= mask_in;
         phase_sel_ff <= phase_sel_in;
         bright_ff    <= bright_in;
         divider_ff   <= divider_in;
         pwm_ff       <= pwm_in;
         drive_ff     <= drive_in;
      end else if (cmd.div_finish) begin
         count_ff <= rem_ff;
         if (rem_ff == 8'd0) phase_ff <= !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         data_ff    <= data_in;
         err_ff     <= err_in;
         led_out_ff <= drive_in;
      end else if (cmd.div_finish) begin
         data_ff    <= 16'd0;
         err_ff     <= 1'b0;
         led_out_ff <= drive_ff;
      end
   end

   assign rsp_read_data = data_ff;
   assign rsp_error     = err_ff;
   assign rsp_led_drive = led_out_ff;

endmodule

`default_nettype wire

// File: rtl/led_blink_dim_register_block_unit.sv
`default_nettype none

// Eight-LED driver with blink and brightness dimming. Every accepted word gives one
// result word. Register accesses and pwm ticks are answered in the cycle after they
// are accepted and may follow one another in consecutive cycles as long as results
// are taken. For a blink pulse the blink counter is advanced modulo the divider by a
// bit-serial remainder unit that retires one of nine numerator bits per cycle, and no
// word is accepted meanwhile. The LED port pattern in led_drive changes only on pwm
// ticks. The default brightness register is loaded into the brightness register at
// reset and is always ready for a write.
module led_blink_dim_register_block_unit
   import ledbd_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   ledbd_req_if.sink  req_chan,
   ledbd_rsp_if.source rsp_chan,
   ledbd_csr_if.sink  csr_chan
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   assign csr_chan.ready = 1'b1;

   ledbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ledbd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_chan.func),
      .req_reg_select (req_chan.reg_select),
      .req_value      (req_chan.value),
      .csr_write      (csr_chan.valid),
      .csr_data       (csr_chan.data),
      .rsp_read_data  (rsp_chan.read_data),
      .rsp_error      (rsp_chan.error),
      .rsp_led_drive  (rsp_chan.led_drive)
   );

endmodule

`default_nettype wire

// File: rtl/ledbd_checker.sv
`default_nettype none

module ledbd_checker
   import ledbd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_read_data,
   input wire logic        rsp_error,
   input wire logic [7:0]  rsp_led_drive
);

   // A stalled result word holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
         $stable(rsp_error) && $stable(rsp_led_drive))
      else $error("result word changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Errors carry the error pattern; good accesses return an 8-bit register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_read_data == ERR_DATA)
      else $error("error word without error data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_read_data[15:8] == 8'd0)
      else $error("register data wider than 8 bits");

   // A new word is taken only when the result slot is free.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> (!rsp_valid || rsp_ready))
      else $error("input accepted while result slot is full");

endmodule

bind led_blink_dim_register_block_unit ledbd_checker u_ledbd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data),
   .rsp_error     (rsp_chan.error),
   .rsp_led_drive (rsp_chan.led_drive)
);

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import ledbd_pkg::*;

   // Codes that the package leaves without a name.
   localparam logic [2:0] FUNC_RESERVED      = 3'd7;
   localparam logic [2:0] REG_UNMAPPED_FIRST = 3'd5;
   localparam logic [2:0] REG_UNMAPPED_LAST  = 3'd7;
   localparam int         MISMATCH_REPORTS   = 10;

   typedef struct packed {
      logic [15:0] read_data;
      logic        error;
      logic [7:0]  led_drive;
   } led_response_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_MOSTLY,
      RX_PERIODIC
   } stall_mode_type;

   logic clock;
   logic reset;

   ledbd_req_if req_bus ();
   ledbd_rsp_if rsp_bus ();
   ledbd_csr_if csr_bus ();

   led_blink_dim_register_block_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predicted state of the LED driver.
   logic [7:0] dflt_bright = DEF_BRIGHT;
   logic [7:0] led_bits;
   logic [7:0] blink_mask;
   logic [7:0] phase_select;
   logic [7:0] bright_level;
   logic [7:0] blink_div;
   logic [7:0] blink_cnt;
   logic       shared_phase;
   logic [7:0] pwm_cnt;
   logic [7:0] drive_pattern;

   led_response_type due_responses[$];
   int unsigned   words_sent      = 0;
   int unsigned   responses_seen  = 0;
   int unsigned   mismatch_count  = 0;
   int unsigned   burst_left      = 0;
   bit            sender_gaps_on  = 1'b1;
   int unsigned   rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic void reset_model();
      dflt_bright   = DEF_BRIGHT;
      led_bits      = 8'h00;
      blink_mask    = 8'h00;
      phase_select  = 8'h00;
      bright_level  = dflt_bright;
      blink_div     = DIV_RESET;
      blink_cnt     = 8'h00;
      shared_phase  = 1'b0;
      pwm_cnt       = 8'h00;
      drive_pattern = ALL_OFF;
   endfunction

   function automatic led_response_type step_led_driver(logic [2:0] func, logic [2:0] sel,
                                                         logic [7:0] value);
      led_response_type rsp;
      logic          ok;
      logic [15:0]   data;
      logic [7:0]    cur;
      logic [7:0]    visible;
      int unsigned   span;
      int            sum;
      ok   = 1'b1;
      data = 16'h0000;
      case (func)
         FUNC_BLINK: begin
            span      = (blink_div == 8'h00) ? 1 : int'(blink_div);
            blink_cnt = 8'((int'(blink_cnt) + 1) % span);
            if (blink_cnt == 8'h00) begin
               shared_phase = ~shared_phase;
            end
         end
         FUNC_PWM: begin
            pwm_cnt = pwm_cnt + 8'd1;
            if (pwm_cnt == 8'h00) begin
               visible       = ~blink_mask | (blink_mask & (phase_select ^ {8{shared_phase}}));
               drive_pattern = ~(led_bits & visible);
            end
            // The compare comes after the wrap, so brightness zero keeps the port dark.
            if (pwm_cnt == bright_level && bright_level != BRIGHT_MAX) begin
               drive_pattern = ALL_OFF;
            end
         end
         FUNC_RESERVED: begin
            ok = 1'b0;
         end
         default: begin
            case (sel)
               REG_LED, REG_MASK, REG_PHASE: begin
                  cur = (sel == REG_LED) ? led_bits : (sel == REG_MASK) ? blink_mask
                                                                         : phase_select;
                  case (func)
                     FUNC_READ:  ;
                     FUNC_WRITE: cur = value;
                     FUNC_COMP:  cur = ~cur;
                     default:    ok = 1'b0;
                  endcase
                  if (ok) begin
                     data = {8'h00, cur};
                     case (sel)
                        REG_LED:  led_bits     = cur;
                        REG_MASK: blink_mask   = cur;
                        default:  phase_select = cur;
                     endcase
                  end
               end
               REG_BRITE: begin
                  case (func)
                     FUNC_READ:  ;
                     FUNC_WRITE: bright_level = value;
                     FUNC_INC: begin
                        sum          = int'(bright_level) + int'(value);
                        bright_level = (sum > int'(BRIGHT_MAX)) ? BRIGHT_MAX : 8'(sum);
                     end
                     FUNC_DEC: begin
                        bright_level = (value > bright_level) ? 8'h00 : bright_level - value;
                     end
                     default: ok = 1'b0;
                  endcase
                  data = {8'h00, bright_level};
               end
               REG_DIV: begin
                  case (func)
                     FUNC_READ: ;
                     FUNC_WRITE: begin
                        if (value != 8'h00) begin
                           blink_div = value;
                        end
                     end
                     FUNC_INC: begin
                        if (blink_div < DIV_MAX) begin
                           blink_div = blink_div + 8'd1;
                        end
                     end
                     FUNC_DEC: begin
                        if (blink_div > DIV_MIN) begin
                           blink_div = blink_div - 8'd1;
                        end
                     end
                     default: ok = 1'b0;
                  endcase
                  data = {8'h00, blink_div};
               end
               default: ok = 1'b0;
            endcase
         end
      endcase
      rsp.read_data = ok ? data : ERR_DATA;
      rsp.error     = ~ok;
      rsp.led_drive = drive_pattern;
      return rsp;
   endfunction

   // Predicts on every accepted word and checks every returned word, in one place so
   // that the order of the two within an edge is fixed.
   always @(posedge clock) begin : response_check
      led_response_type want;
      if (reset) begin
         reset_model();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            dflt_bright = csr_bus.data;
         end
         if (req_bus.valid && req_bus.ready) begin
            due_responses.push_back(step_led_driver(req_bus.func, req_bus.reg_select,
                                                    req_bus.value));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            responses_seen++;
            if (due_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_REPORTS) begin
                  $display("%0t: response word with none expected: data %h err %b drive %h",
                           $realtime, rsp_bus.read_data, rsp_bus.error, rsp_bus.led_drive);
               end
            end else begin
               want = due_responses.pop_front();
               if (rsp_bus.read_data !== want.read_data || rsp_bus.error !== want.error ||
                   rsp_bus.led_drive !== want.led_drive) begin
                  mismatch_count++;
                  if (mismatch_count <= MISMATCH_REPORTS) begin
                     $display("%0t: mismatch: expected data %h err %b drive %h, got %h %b %h",
                              $realtime, want.read_data, want.error, want.led_drive,
                              rsp_bus.read_data, rsp_bus.error, rsp_bus.led_drive);
                  end
               end
            end
         end
      end
   end

   // Result side: stalls follow a mode that changes now and then, and a requested
   // hold-off keeps ready low for a counted number of cycles.
   initial begin : result_stall
      stall_mode_type mode;
      int unsigned mode_left;
      int unsigned tick;
      mode      = RX_STEADY;
      mode_left = 0;
      tick      = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (mode)
               RX_STEADY: rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_MOSTLY: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               default:   rsp_bus.ready <= ((tick % 5) != 0);
            endcase
         end
      end
   end

   task automatic send_word(input logic [2:0] func, input logic [2:0] sel,
                            input logic [7:0] value);
      if (burst_left == 0) begin
         if (sender_gaps_on) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.func       <= func;
      req_bus.reg_select <= sel;
      req_bus.value      <= value;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (responses_seen != words_sent) begin
         @(posedge clock);
      end
   endtask

   // Only takes effect at a reset, so the returned words must not change.
   task automatic write_default_brightness(input logic [7:0] level);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= level;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_register_access();
      send_word(FUNC_READ, REG_LED, 8'h00);
      send_word(FUNC_WRITE, REG_LED, 8'hFF);
      send_word(FUNC_COMP, REG_LED, 8'h00);
      send_word(FUNC_WRITE, REG_MASK, 8'hFF);
      send_word(FUNC_COMP, REG_MASK, 8'hFF);
      send_word(FUNC_WRITE, REG_PHASE, 8'h0F);
      send_word(FUNC_COMP, REG_PHASE, 8'h00);
      send_word(FUNC_READ, REG_BRITE, 8'h00);
      send_word(FUNC_INC, REG_BRITE, 8'hFF);
      send_word(FUNC_DEC, REG_BRITE, 8'hFF);
      send_word(FUNC_DEC, REG_BRITE, 8'h01);
      send_word(FUNC_WRITE, REG_BRITE, 8'h80);
      send_word(FUNC_INC, REG_BRITE, 8'h90);
      send_word(FUNC_WRITE, REG_DIV, 8'h00);
      send_word(FUNC_WRITE, REG_DIV, 8'hFF);
      send_word(FUNC_INC, REG_DIV, 8'h00);
      send_word(FUNC_WRITE, REG_DIV, 8'h01);
      send_word(FUNC_DEC, REG_DIV, 8'h00);
      send_word(FUNC_WRITE, REG_DIV, DIV_RESET);
   endtask

   task automatic test_unsupported();
      send_word(FUNC_COMP, REG_BRITE, 8'h00);
      send_word(FUNC_COMP, REG_DIV, 8'h00);
      send_word(FUNC_INC, REG_LED, 8'h01);
      send_word(FUNC_DEC, REG_MASK, 8'h01);
      for (int sel = REG_UNMAPPED_FIRST; sel <= REG_UNMAPPED_LAST; sel++) begin
         send_word(FUNC_READ, 3'(sel), 8'h00);
      end
      send_word(FUNC_RESERVED, REG_LED, 8'hFF);
      send_word(FUNC_BLINK, REG_UNMAPPED_LAST, 8'hFF);
      send_word(FUNC_PWM, REG_UNMAPPED_LAST, 8'hFF);
   endtask

   // Frames of register setup and blink pulses, each followed by a run of pwm ticks
   // that is mostly long enough to cross a counter wrap.
   task automatic test_blink_and_dim(input int unsigned budget);
      int unsigned start;
      int unsigned run;
      logic [7:0]  level;
      start = words_sent;
      while (words_sent - start < budget) begin
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(3, 12)) begin
            case ($urandom_range(0, 9))
               0: send_word(FUNC_WRITE, REG_LED, 8'($urandom));
               1: send_word(FUNC_COMP, 3'($urandom_range(REG_LED, REG_PHASE)), 8'($urandom));
               2: send_word(FUNC_WRITE, REG_MASK, 8'($urandom));
               3: send_word(FUNC_WRITE, REG_PHASE, 8'($urandom));
               4: begin
                  case ($urandom_range(0, 4))
                     0:       level = 8'h00;
                     1:       level = 8'h01;
                     2:       level = BRIGHT_MAX - 8'd1;
                     3:       level = BRIGHT_MAX;
                     default: level = 8'($urandom);
                  endcase
                  send_word(FUNC_WRITE, REG_BRITE, level);
               end
               5: send_word($urandom_range(0, 1) ? FUNC_INC : FUNC_DEC, REG_BRITE,
                            8'($urandom));
               6: send_word(FUNC_WRITE, REG_DIV, ($urandom_range(0, 7) == 0) ? DIV_MAX
                                                 : 8'($urandom_range(0, 6)));
               7: send_word($urandom_range(0, 1) ? FUNC_INC : FUNC_DEC, REG_DIV,
                            8'($urandom));
               8: send_word(FUNC_READ, 3'($urandom_range(REG_LED, REG_DIV)), 8'($urandom));
               default: send_word(FUNC_BLINK, 3'($urandom), 8'($urandom));
            endcase
         end
         repeat ($urandom_range(0, 8)) begin
            send_word(FUNC_BLINK, 3'($urandom), 8'($urandom));
         end
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(200, 300);
         repeat (run) begin
            send_word(FUNC_PWM, 3'($urandom), 8'($urandom));
         end
      end
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_random_mix(input int unsigned count);
      repeat (count) begin
         send_word($urandom_range(0, 1) ? FUNC_PWM : 3'($urandom), 3'($urandom),
                   8'($urandom));
      end
   endtask

   // The result side holds off while words keep coming, so the block must stall its
   // input; afterwards the sender waits until every result is back.
   task automatic test_backpressure();
      sender_gaps_on  = 1'b0;
      rsp_hold_cycles = $urandom_range(120, 200);
      test_random_mix(48);
      sender_gaps_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= FUNC_READ;
      req_bus.reg_select <= REG_LED;
      req_bus.value      <= 8'h00;
      csr_bus.valid      <= 1'b0;
      csr_bus.data       <= 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_default_brightness(8'h00);
      test_register_access();
      test_unsupported();
      wait_drained();
      write_default_brightness(BRIGHT_MAX);
      test_blink_and_dim(700);
      wait_drained();
      write_default_brightness(8'($urandom));
      test_backpressure();
      write_default_brightness(8'($urandom));
      test_random_mix(250);
      wait_drained();
      write_default_brightness(8'h00);
      test_blink_and_dim(550);
      wait_drained();
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && due_responses.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
